// ===== rtl/bernstein_basis_value_derivative_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the Bernstein basis value and slope unit
// Short forms for concurrent checks clocked on clk, reset by rst_n.
// ---------------------------------------------------------------------------
`ifndef BERNSTEIN_BASIS_VALUE_DERIVATIVE_ASSERT_SVH
`define BERNSTEIN_BASIS_VALUE_DERIVATIVE_ASSERT_SVH

// same-cycle implication
`define BBVD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BBVD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bbvd_pkg.sv =====
// ---------------------------------------------------------------------------
// bbvd_pkg
// Shared types and constants for the Bernstein basis value and slope unit.
// ---------------------------------------------------------------------------
package bbvd_pkg;

  localparam int MAX_DEGREE = 15;
  localparam int DEPTH      = MAX_DEGREE + 1;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int DEG_W      = 4;
  localparam int POS_W      = 18;
  localparam int VAL_W      = 17;
  localparam int SLOPE_W    = 20;
  localparam int X_W        = 18;

  localparam logic [VAL_W-1:0]        ONE_Q16 = 17'd65536;
  localparam logic signed [POS_W-1:0] POS_MAX = 18'sd65536;
  localparam logic signed [POS_W-1:0] POS_MIN = -18'sd65536;
  localparam logic [DEG_W-1:0]        DEGREE_RESET = 4'd3;

  // input word
  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    last_point;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [DEG_W-1:0]          basis_index;
    logic [VAL_W-1:0]          basis_value;
    logic signed [SLOPE_W-1:0] basis_slope;
    logic                      last_of_run;
    logic                      batch_end;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_LOAD,
    OP_STEP,
    OP_EMIT
  } op_t;

  // controller to datapath
  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic             first;
    logic             use_right;
    logic             last;
    logic [DEG_W-1:0] degree;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
  } stat_t;

endpackage

// ===== rtl/bbvd_ctrl.sv =====
// ---------------------------------------------------------------------------
// bbvd_ctrl
// Sequencer: holds the degree register, walks the recursion rows and result
// indices, and issues one datapath command per cycle unless a result stalls.
// ---------------------------------------------------------------------------
module bbvd_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cfg_we,
  input  logic [bbvd_pkg::DEG_W-1:0]    cfg_wdata,
  input  bbvd_pkg::stat_t               stat,
  output bbvd_pkg::cmd_t                cmd
);

  bbvd_pkg::state_t             state_r, state_nxt;
  logic [bbvd_pkg::DEG_W-1:0]   degree_r, degree_nxt;
  logic [bbvd_pkg::DEG_W-1:0]   n_r, n_nxt;
  logic [bbvd_pkg::IDX_W-1:0]   row_r, row_nxt;
  logic [bbvd_pkg::IDX_W-1:0]   col_r, col_nxt;
  logic [bbvd_pkg::IDX_W-1:0]   k_r, k_nxt;
  logic                         accept;
  logic                         row_done;
  logic                         last_row;
  logic                         emit_go;

  assign accept   = in_valid && in_ready;
  // column reached row+1 ends a row; row n-2 is the final one
  assign row_done = ({1'b0, col_r} == {1'b0, row_r} + 5'd1);
  assign last_row = ({1'b0, row_r} + 5'd2 == {1'b0, n_r});
  assign emit_go  = (state_r == bbvd_pkg::ST_EMIT) && stat.slot_free;

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bbvd_pkg::ST_IDLE;
      degree_r <= bbvd_pkg::DEGREE_RESET;
      n_r      <= '0;
      row_r    <= '0;
      col_r    <= '0;
      k_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      degree_r <= degree_nxt;
      n_r      <= n_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      k_r      <= k_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bbvd_pkg::ST_IDLE: begin
        if (accept) begin
          if (degree_r inside {4'd0, 4'd1}) state_nxt = bbvd_pkg::ST_EMIT;
          else                              state_nxt = bbvd_pkg::ST_BUILD;
        end
      end
      bbvd_pkg::ST_BUILD: begin
        if (row_done && last_row) state_nxt = bbvd_pkg::ST_EMIT;
      end
      bbvd_pkg::ST_EMIT: begin
        if (emit_go && (k_r == n_r)) state_nxt = bbvd_pkg::ST_IDLE;
      end
      default: state_nxt = bbvd_pkg::ST_IDLE;
    endcase
  end

  // counters and configuration
  always_comb begin
    degree_nxt = cfg_we ? cfg_wdata : degree_r;
    n_nxt      = n_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    k_nxt      = k_r;
    case (state_r)
      bbvd_pkg::ST_IDLE: begin
        if (accept) begin
          n_nxt   = degree_r;
          row_nxt = '0;
          col_nxt = '0;
          k_nxt   = '0;
        end
      end
      bbvd_pkg::ST_BUILD: begin
        if (row_done) begin
          row_nxt = row_r + 4'd1;
          col_nxt = '0;
        end else begin
          col_nxt = col_r + 4'd1;
        end
      end
      bbvd_pkg::ST_EMIT: begin
        if (emit_go) k_nxt = k_r + 4'd1;
      end
      default: begin
        k_nxt = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd.op        = bbvd_pkg::OP_NONE;
    cmd.idx       = '0;
    cmd.first     = 1'b0;
    cmd.use_right = 1'b0;
    cmd.last      = 1'b0;
    cmd.degree    = n_r;
    case (state_r)
      bbvd_pkg::ST_IDLE: begin
        // ready is always high here, so a valid word is taken
        in_ready = 1'b1;
        if (in_valid) cmd.op = bbvd_pkg::OP_LOAD;
      end
      bbvd_pkg::ST_BUILD: begin
        cmd.op        = bbvd_pkg::OP_STEP;
        cmd.idx       = col_r;
        cmd.first     = (col_r == '0);
        cmd.use_right = !row_done;
      end
      bbvd_pkg::ST_EMIT: begin
        if (emit_go) cmd.op = bbvd_pkg::OP_EMIT;
        cmd.idx       = k_r;
        cmd.first     = (k_r == '0);
        cmd.use_right = (k_r < n_r);
        cmd.last      = (k_r == n_r);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/bbvd_dpath.sv =====
// ---------------------------------------------------------------------------
// bbvd_dpath
// Datapath: clamps the position, holds the basis scratch row, runs the
// shared multiply-and-round unit and the result register.
// ---------------------------------------------------------------------------
module bbvd_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  bbvd_pkg::in_word_t  in_data,
  input  bbvd_pkg::cmd_t      cmd,
  output bbvd_pkg::stat_t     stat,
  output logic                out_valid,
  input  logic                out_ready,
  output bbvd_pkg::out_word_t out_data
);

  logic [bbvd_pkg::VAL_W-1:0]   scratch_r [bbvd_pkg::DEPTH];
  logic [bbvd_pkg::X_W-1:0]     x_r;
  logic                         last_r;
  logic [bbvd_pkg::VAL_W-1:0]   carry_r;
  logic                         out_valid_r, out_valid_nxt;
  bbvd_pkg::out_word_t          out_data_r;

  logic signed [bbvd_pkg::POS_W-1:0] pos_clamp;
  logic signed [bbvd_pkg::POS_W:0]   x_wide;
  logic [bbvd_pkg::VAL_W-1:0]        left_v;
  logic [bbvd_pkg::VAL_W-1:0]        right_v;
  logic signed [bbvd_pkg::VAL_W:0]   diff;
  logic signed [36:0]                prod;
  logic signed [36:0]                prod_rnd;
  logic signed [17:0]                corr;
  logic [17:0]                       mix;
  logic signed [22:0]                slope_raw;
  logic signed [22:0]                slope_half;
  logic [bbvd_pkg::VAL_W-1:0]        value_v;

  // clamp t to [-1,1] and map to x = t + 1 (Q17 of (t+1)/2)
  always_comb begin
    if (in_data.position > bbvd_pkg::POS_MAX)      pos_clamp = bbvd_pkg::POS_MAX;
    else if (in_data.position < bbvd_pkg::POS_MIN) pos_clamp = bbvd_pkg::POS_MIN;
    else                                           pos_clamp = in_data.position;
    x_wide = {pos_clamp[bbvd_pkg::POS_W-1], pos_clamp} + 19'sd65536;
  end

  // shared mix: x*l + (1-x)*r = r + x*(l-r), rounded half up
  always_comb begin
    left_v   = cmd.first ? '0 : carry_r;
    right_v  = cmd.use_right ? scratch_r[cmd.idx] : '0;
    diff     = $signed({1'b0, left_v}) - $signed({1'b0, right_v});
    prod     = $signed({1'b0, x_r}) * diff;
    prod_rnd = (prod + 37'sd65536) >>> 17;
    corr     = prod_rnd[17:0];
    mix      = {1'b0, right_v} + corr;
  end

  // slope: n*(l-r) halved, halves away from zero
  always_comb begin
    slope_raw = $signed({1'b0, cmd.degree}) * diff;
    if (slope_raw[22]) slope_half = slope_raw >>> 1;
    else               slope_half = (slope_raw + 23'sd1) >>> 1;
    value_v = (cmd.degree == '0) ? bbvd_pkg::ONE_Q16 : mix[bbvd_pkg::VAL_W-1:0];
  end

  // item registers and scratch row
  always_ff @(posedge clk) begin
    case (cmd.op)
      bbvd_pkg::OP_LOAD: begin
        x_r                <= x_wide[bbvd_pkg::X_W-1:0];
        last_r             <= in_data.last_point;
        scratch_r[4'd0]    <= bbvd_pkg::ONE_Q16;
      end
      bbvd_pkg::OP_STEP: begin
        scratch_r[cmd.idx] <= mix[bbvd_pkg::VAL_W-1:0];
        carry_r            <= right_v;
      end
      bbvd_pkg::OP_EMIT: begin
        carry_r                 <= right_v;
        out_data_r.basis_index  <= cmd.idx;
        out_data_r.basis_value  <= value_v;
        out_data_r.basis_slope  <= slope_half[bbvd_pkg::SLOPE_W-1:0];
        out_data_r.last_of_run  <= cmd.last;
        out_data_r.batch_end    <= cmd.last && last_r;
      end
      default: begin
        carry_r <= carry_r;
      end
    endcase
  end

  // result word valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.op == bbvd_pkg::OP_EMIT) out_valid_nxt = 1'b1;
    else if (out_ready)              out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  assign stat.slot_free = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;

endmodule

// ===== rtl/bernstein_basis_value_derivative.sv =====
// ---------------------------------------------------------------------------
// bernstein_basis_value_derivative
// Bernstein basis values and slopes of degree n at one point per word.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one position word (t in Q16, clamped to [-1,1]) plus a batch mark.
//   out_* : n+1 result words per position, k = 0..n, the last one flagged
//           with last_of_run and carrying the batch mark in batch_end.
//   cfg_* : degree register (reset 3); the user writes it only while the
//           block is idle, and the block itself does not enforce this.
// Timing: a word is taken only in the idle state. A load step captures it,
//   the order n-1 basis is then built one mix per cycle on the single shared
//   multiply-round unit, and the n+1 results are emitted in order of k. The
//   build phase is skipped for n = 0 and n = 1. Each result is captured in
//   the result register as it is emitted, so the output is registered.
// Stall: a held result stops the emit walk; the build phase carries on.
//   A new word may be taken while the final result still waits.
// Reset: synchronous on rst_n low; degree returns to 3, no result pending.
// ---------------------------------------------------------------------------
`include "bernstein_basis_value_derivative_assert.svh"

module bernstein_basis_value_derivative (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bbvd_pkg::in_word_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bbvd_pkg::out_word_t        out_data,
  input  logic                       cfg_we,
  input  logic [bbvd_pkg::DEG_W-1:0] cfg_wdata
);

  bbvd_pkg::cmd_t  cmd;
  bbvd_pkg::stat_t stat;

  // sequencer
  bbvd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic and result register
  bbvd_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // checks
  `BBVD_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "word taken while busy")
  `BBVD_ASSERT_NOW(a_end_on_last, out_valid && out_data.batch_end, out_data.last_of_run, "batch_end off last result")
  `BBVD_ASSERT_NOW(a_value_range, out_valid, out_data.basis_value <= bbvd_pkg::ONE_Q16, "basis value above one")

endmodule

// ===== test/tb.sv =====
// ---------------------------------------------------------------------------
// tb: Bernstein basis value and slope unit testbench
// Feeds position words through the valid/ready input channel and compares
// every result word, field by field, with a basis worked out in the bench.
// Degree changes are written only once the unit has drained. There is a
// short directed part first, then random batches at several degrees, with
// random gaps and stalls on both channels.
// ---------------------------------------------------------------------------
module tb;

  localparam longint ONE_Q17   = 131072;
  localparam int     SETTLE    = 8;     // idle cycles before a degree write
  localparam int     TAIL      = 40;    // cycles watched after the last word
  localparam int     WATCHDOG  = 4000;  // cycles without any handshake

  typedef enum logic [1:0] {
    ACT_POINT,
    ACT_DEGREE,
    ACT_SETTLE
  } act_t;

  typedef struct {
    act_t                       act;
    bbvd_pkg::in_word_t         word;
    logic [bbvd_pkg::DEG_W-1:0] deg;
  } script_t;

  logic                       clk;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  bbvd_pkg::in_word_t         in_data   = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  bbvd_pkg::out_word_t        out_data;
  logic                       cfg_we    = 1'b0;
  logic [bbvd_pkg::DEG_W-1:0] cfg_wdata = '0;

  script_t             script_q[$];
  bbvd_pkg::out_word_t basis_due[$];
  int                  degree_now = bbvd_pkg::DEGREE_RESET;
  int                  mismatches = 0;
  int                  send_gap = 0, send_burst = 0, settle_cnt = 0;
  int                  stall_left = 0, recv_burst = 0;
  int                  quiet_cycles = 0;

  bernstein_basis_value_derivative dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---- helpers ------------------------------------------------------------

  task automatic flag_error(input string msg);
    mismatches++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // mostly short pauses, a few long ones, and occasional runs with none
  function automatic int idle_len(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst = $urandom_range(20, 50);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // weighted mix of two Q16 terms with Q17 weights, rounded half up
  function automatic longint mix_q17(input longint wl, input longint lo,
                                     input longint wr, input longint hi);
    return (wl * lo + wr * hi + bbvd_pkg::ONE_Q16) >>> 17;
  endfunction

  // expected result words for one accepted position at the current degree
  task automatic predict_basis(input bbvd_pkg::in_word_t w);
    longint              lower [bbvd_pkg::DEPTH];
    longint              t, wx, wa, lo_term, hi_term, v, slope, val;
    int                  n;
    bbvd_pkg::out_word_t r;
    t = w.position;
    if (t > 65536) t = 65536;
    if (t < -65536) t = -65536;
    n = degree_now;
    if (n > bbvd_pkg::MAX_DEGREE) n = bbvd_pkg::MAX_DEGREE;
    wx = t + 65536;
    wa = ONE_Q17 - wx;
    if (n == 0) begin
      r.basis_index = '0;
      r.basis_value = bbvd_pkg::ONE_Q16;
      r.basis_slope = '0;
      r.last_of_run = 1'b1;
      r.batch_end   = w.last_point;
      basis_due.push_back(r);
      return;
    end
    // order n-1 basis, built in place
    lower[0] = bbvd_pkg::ONE_Q16;
    for (int i = 0; i + 1 < n; i++) begin
      lower[i+1] = mix_q17(wx, lower[i], 0, 0);
      for (int j = i; j > 0; j--)
        lower[j] = mix_q17(wx, lower[j-1], wa, lower[j]);
      lower[0] = mix_q17(0, 0, wa, lower[0]);
    end
    // order n value and slope per index
    for (int k = 0; k <= n; k++) begin
      lo_term = (k > 0) ? lower[k-1] : 0;
      hi_term = (k < n) ? lower[k] : 0;
      v       = n * (lo_term - hi_term);
      slope   = (v >= 0) ? (v + 1) / 2 : -((-v + 1) / 2);
      val     = mix_q17(wx, lo_term, wa, hi_term);
      r.basis_index = k[bbvd_pkg::DEG_W-1:0];
      r.basis_value = val[bbvd_pkg::VAL_W-1:0];
      r.basis_slope = slope[bbvd_pkg::SLOPE_W-1:0];
      r.last_of_run = (k == n);
      r.batch_end   = (k == n) ? w.last_point : 1'b0;
      basis_due.push_back(r);
    end
  endtask

  task automatic add_point(input int pos, input bit last);
    script_t s;
    s.act             = ACT_POINT;
    s.word.position   = pos[bbvd_pkg::POS_W-1:0];
    s.word.last_point = last;
    s.deg             = '0;
    script_q.push_back(s);
  endtask

  task automatic add_degree(input int d);
    script_t s;
    s.act  = ACT_DEGREE;
    s.word = '0;
    s.deg  = d[bbvd_pkg::DEG_W-1:0];
    script_q.push_back(s);
  endtask

  task automatic add_settle();
    script_t s;
    s.act  = ACT_SETTLE;
    s.word = '0;
    s.deg  = '0;
    script_q.push_back(s);
  endtask

  // ---- driver: input words and degree writes -------------------------------
  always @(posedge clk) begin
    script_t head;
    logic    we_next;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      cfg_we     <= 1'b0;
      cfg_wdata  <= '0;
      send_gap   = 0;
      settle_cnt = 0;
    end else begin
      we_next = 1'b0;
      if (in_valid && in_ready)
        predict_basis(in_data);
      if (in_valid && !in_ready) begin
        // word still held, keep it as is
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (script_q.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        head = script_q[0];
        case (head.act)
          ACT_POINT: begin
            in_data  <= head.word;
            in_valid <= 1'b1;
            void'(script_q.pop_front());
            send_gap = idle_len(send_burst);
          end
          ACT_SETTLE: begin
            in_valid <= 1'b0;
            if (basis_due.size() == 0)
              void'(script_q.pop_front());
          end
          default: begin
            // degree write once drained and quiet for a while
            in_valid <= 1'b0;
            if (basis_due.size() != 0) begin
              settle_cnt = 0;
            end else if (settle_cnt < SETTLE) begin
              settle_cnt++;
            end else begin
              we_next    = 1'b1;
              cfg_wdata  <= head.deg;
              degree_now = head.deg;
              settle_cnt = 0;
              void'(script_q.pop_front());
            end
          end
        endcase
      end
      cfg_we <= we_next;
    end
  end

  // ---- monitor: result words and receiver stalls ---------------------------
  always @(posedge clk) begin
    bbvd_pkg::out_word_t want;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (basis_due.size() == 0) begin
          flag_error($sformatf("result word %h with none expected", out_data));
        end else begin
          want = basis_due.pop_front();
          if (out_data.basis_index !== want.basis_index)
            flag_error($sformatf("index got %0d want %0d",
                                 out_data.basis_index, want.basis_index));
          if (out_data.basis_value !== want.basis_value)
            flag_error($sformatf("value k=%0d got %0d want %0d", want.basis_index,
                                 out_data.basis_value, want.basis_value));
          if (out_data.basis_slope !== want.basis_slope)
            flag_error($sformatf("slope k=%0d got %0d want %0d", want.basis_index,
                                 out_data.basis_slope, want.basis_slope));
          if (out_data.last_of_run !== want.last_of_run)
            flag_error($sformatf("last_of_run k=%0d got %b want %b", want.basis_index,
                                 out_data.last_of_run, want.last_of_run));
          if (out_data.batch_end !== want.batch_end)
            flag_error($sformatf("batch_end k=%0d got %b want %b", want.basis_index,
                                 out_data.batch_end, want.batch_end));
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = idle_len(recv_burst);
        out_ready <= (stall_left == 0);
      end
    end
  end

  // ---- watchdog ------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---- stimulus script and end of run --------------------------------------
  initial begin
    int phase_deg [8];
    int len, pick, pos;

    // reset degree: ends of range, clamping, sign bit, odd values
    add_point(-65536, 1'b0);
    add_point(65536, 1'b0);
    add_point(0, 1'b0);
    add_point(1, 1'b0);
    add_point(-1, 1'b0);
    add_point(32768, 1'b0);
    add_point(-32768, 1'b0);
    add_point(65537, 1'b0);
    add_point(-65537, 1'b0);
    add_point(131071, 1'b0);
    add_point(-131072, 1'b0);
    add_point(12345, 1'b1);
    // degree zero
    add_degree(0);
    add_point(0, 1'b0);
    add_point(65536, 1'b1);
    add_point(-131072, 1'b0);
    // highest degree
    add_degree(15);
    add_point(-65536, 1'b0);
    add_point(65536, 1'b0);
    add_point(0, 1'b0);
    add_point(1, 1'b1);
    // degree one
    add_degree(1);
    add_point(0, 1'b1);
    add_point(-1, 1'b0);
    add_point(65535, 1'b1);
    add_settle();

    // random batches at several degrees
    phase_deg = '{2, 15, 0, 1, 7, 0, 0, 4};
    phase_deg[5] = $urandom_range(0, 15);
    phase_deg[6] = $urandom_range(0, 15);
    foreach (phase_deg[p]) begin
      add_degree(phase_deg[p]);
      len = 20;
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80)
          pos = int'($urandom_range(0, 131072)) - 65536;
        else if (pick < 88)
          pos = ($urandom_range(0, 1) != 0) ? 65536 : -65536;
        else
          pos = int'($urandom_range(0, 262143)) - 131072;
        add_point(pos, ($urandom_range(0, 3) == 0));
        if (i == 9 && $urandom_range(0, 1) != 0)
          add_settle();
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (script_q.size() != 0 || in_valid || basis_due.size() != 0);
    repeat (TAIL) @(negedge clk);

    if (mismatches == 0 && basis_due.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bbvd_pkg.sv
rtl/bbvd_ctrl.sv
rtl/bbvd_dpath.sv
rtl/bernstein_basis_value_derivative.sv
test/tb.sv
